### rtl/core/ledscan_pkg.sv
// ----------------------------------------------------------------------------
// ledscan_pkg
// Shared types and constants for the multiplexed RGB LED PWM scanner.
// ----------------------------------------------------------------------------
package ledscan_pkg;

  // Number of LEDs in the frame buffer (1 to 256).
  localparam int LED_COUNT = 64;
  localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);

  localparam logic [8:0] MAX_LEVELS = 9'd256;

  // Item commands.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PWM_LEVELS  = 2'd0;
  localparam logic [1:0] REG_SCAN_ENABLE = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_t;

endpackage

### rtl/core/ledscan_ctrl.sv
// ----------------------------------------------------------------------------
// ledscan_ctrl
// Two-state sequencer: capture an item, then execute it and strobe the result.
// ----------------------------------------------------------------------------
module ledscan_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output ledscan_pkg::ctl_t  ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  assign busy        = (state == ST_EXEC);
  assign ctl.capture = (state == ST_IDLE) && start;
  assign ctl.execute = (state == ST_EXEC);

endmodule

### rtl/core/ledscan_dp.sv
// ----------------------------------------------------------------------------
// ledscan_dp
// Frame buffer memory, scan counters, drive hold and result registers.
// ----------------------------------------------------------------------------
module ledscan_dp (
  input  logic              clk,
  input  logic              rst,
  input  ledscan_pkg::ctl_t ctl,
  input  logic [1:0]        command,
  input  logic [7:0]        led_index,
  input  logic [7:0]        red_value,
  input  logic [7:0]        green_value,
  input  logic [7:0]        blue_value,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  output logic [7:0]        anode_select,
  output logic              anode_on,
  output logic              red_on,
  output logic              green_on,
  output logic              blue_on,
  output logic [7:0]        read_red,
  output logic [7:0]        read_green,
  output logic [7:0]        read_blue,
  output logic              index_error
);

  localparam int IW = ledscan_pkg::IDX_W;

  // Frame buffer with a valid bit per entry; an invalid entry reads as zero.
  logic [23:0]                       mem [ledscan_pkg::LED_COUNT];
  logic [ledscan_pkg::LED_COUNT-1:0] valid;
  logic [23:0]                       mem_q;
  logic                              vld_q;
  logic [IW-1:0]                     rd_addr;

  // Captured item.
  logic [1:0]  cmd_q;
  logic [7:0]  idx_q;
  logic [23:0] wdata_q;

  // Configuration and scan state.
  logic [8:0]  pwm_levels;
  logic        scan_enable;
  logic [7:0]  scan_position;
  logic [7:0]  scan_level;
  logic [11:0] drive_hold;

  logic [23:0] col;
  logic        ok;
  logic [8:0]  level_count;
  logic [8:0]  pos_inc;
  logic [8:0]  lvl_inc;
  logic        pos_wrap;
  logic [11:0] hold_tick;

  assign rd_addr = (command == ledscan_pkg::CMD_TICK) ? scan_position[IW-1:0]
                                                      : led_index[IW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      mem_q <= mem[rd_addr];
    end
    if (ctl.execute && cmd_q == ledscan_pkg::CMD_WRITE && ok) begin
      mem[idx_q[IW-1:0]] <= wdata_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ctl.capture) vld_q <= valid[rd_addr];
      if (ctl.execute) begin
        if (cmd_q == ledscan_pkg::CMD_CLEAR) begin
          valid <= '0;
        end else if (cmd_q == ledscan_pkg::CMD_WRITE && ok) begin
          valid[idx_q[IW-1:0]] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= command;
      idx_q   <= led_index;
      wdata_q <= {red_value, green_value, blue_value};
    end
  end

  assign col = vld_q ? mem_q : 24'd0;
  assign ok  = ({1'b0, idx_q} < ledscan_pkg::LED_LIMIT);

  assign level_count = (pwm_levels == 9'd0 || pwm_levels > ledscan_pkg::MAX_LEVELS)
                       ? ledscan_pkg::MAX_LEVELS : pwm_levels;
  assign pos_inc  = {1'b0, scan_position} + 9'd1;
  assign lvl_inc  = {1'b0, scan_level} + 9'd1;
  assign pos_wrap = (pos_inc >= ledscan_pkg::LED_LIMIT);

  assign hold_tick = {(scan_level < col[7:0]),
                      (scan_level < col[15:8]),
                      (scan_level < col[23:16]),
                      1'b1,
                      scan_position};

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_levels    <= ledscan_pkg::MAX_LEVELS;
      scan_enable   <= 1'b0;
      scan_position <= 8'd0;
      scan_level    <= 8'd0;
      drive_hold    <= 12'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ledscan_pkg::REG_PWM_LEVELS: begin
            pwm_levels <= cfg_data;
          end
          ledscan_pkg::REG_SCAN_ENABLE: begin
            scan_enable <= cfg_data[0];
            if (!cfg_data[0]) drive_hold <= 12'd0;
          end
          default: begin
          end
        endcase
      end
      if (ctl.execute && cmd_q == ledscan_pkg::CMD_TICK) begin
        if (!scan_enable) begin
          drive_hold <= 12'd0;
        end else begin
          drive_hold <= hold_tick;
          if (pos_wrap) begin
            scan_position <= 8'd0;
            scan_level    <= (lvl_inc >= level_count) ? 8'd0 : lvl_inc[7:0];
          end else begin
            scan_position <= pos_inc[7:0];
          end
        end
      end
    end
  end

  // Read data is returned only for an in-range read; every other item
  // leaves the read fields at zero.
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      case (cmd_q)
        ledscan_pkg::CMD_WRITE: begin
          read_red    <= 8'd0;
          read_green  <= 8'd0;
          read_blue   <= 8'd0;
          index_error <= !ok;
        end
        ledscan_pkg::CMD_READ: begin
          read_red    <= ok ? col[23:16] : 8'd0;
          read_green  <= ok ? col[15:8]  : 8'd0;
          read_blue   <= ok ? col[7:0]   : 8'd0;
          index_error <= !ok;
        end
        default: begin
          read_red    <= 8'd0;
          read_green  <= 8'd0;
          read_blue   <= 8'd0;
          index_error <= 1'b0;
        end
      endcase
    end
  end

  assign anode_select = drive_hold[7:0];
  assign anode_on     = drive_hold[8];
  assign red_on       = drive_hold[9];
  assign green_on     = drive_hold[10];
  assign blue_on      = drive_hold[11];

endmodule

### rtl/core/multiplexed_rgb_led_pwm_scanner.sv
// ----------------------------------------------------------------------------
// multiplexed_rgb_led_pwm_scanner
// Frame buffer of RGB colors driving a multiplexed LED array with PWM.
// ----------------------------------------------------------------------------
// Usage:
// An item is issued by raising start with command, led_index and the three
// color values; it is taken at a clock edge where start is high and busy is
// low. Commands are a scan tick, a color write, a color read and a buffer
// clear. Every item yields exactly one result, shown for one cycle with
// done high. The drive fields always show the held anode and color lines.
// An accepted item is executed in the execute state and done follows it;
// a new item can be taken in the done cycle, but not while one executes.
// This sequence is set by the registered read of the frame buffer memory:
// the entry is read at capture, then the item is evaluated and registered.
// The receiver cannot stall, so results are never held back.
// Configuration (level count, scan enable) is written through the cfg_*
// channel, which is always ready and should be used only while idle.
// Writing scan enable to zero turns the drive outputs off at once.
// Synchronous reset clears the buffer (through per-entry valid bits), the
// scan position and level, the drive outputs, and restores 256 levels with
// scanning disabled. No clearing pass is needed after reset.
module multiplexed_rgb_led_pwm_scanner (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [7:0] led_index,
  input  logic [7:0] red_value,
  input  logic [7:0] green_value,
  input  logic [7:0] blue_value,
  output logic       done,
  output logic [7:0] anode_select,
  output logic       anode_on,
  output logic       red_on,
  output logic       green_on,
  output logic       blue_on,
  output logic [7:0] read_red,
  output logic [7:0] read_green,
  output logic [7:0] read_blue,
  output logic       index_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  ledscan_pkg::ctl_t ctl;

  // The user must issue configuration writes only while the block is idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  ledscan_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  ledscan_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .command      (command),
    .led_index    (led_index),
    .red_value    (red_value),
    .green_value  (green_value),
    .blue_value   (blue_value),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .anode_select (anode_select),
    .anode_on     (anode_on),
    .red_on       (red_on),
    .green_on     (green_on),
    .blue_on      (blue_on),
    .read_red     (read_red),
    .read_green   (read_green),
    .read_blue    (read_blue),
    .index_error  (index_error)
  );

  // An accepted item always moves into execution on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not enter execution");

  // Execution always ends in exactly one result strobe.
  assert property (@(posedge clk) disable iff (rst) busy |=> (done && !busy))
    else $error("execution did not produce a result strobe");

  // A result strobe is never raised without an item just executed.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without an executed item");

  // A flagged index never returns color data.
  assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (read_red == 8'd0 && read_green == 8'd0 &&
                               read_blue == 8'd0))
    else $error("index error with nonzero read data");

endmodule
